// ===== design/etxpad_pkg.sv =====
// ============================================================================
// etxpad_pkg: shared types and constants for the Ethernet transmit framer
// Holds the command word passed from the front end to the back end, the
// back-end phase encoding and the byte-wide reflected CRC-32 update.
// ============================================================================
package etxpad_pkg;

    localparam int MIN_PAYLOAD_DEF = 46;
    localparam int MAX_PAYLOAD_DEF = 1500;

    // The payload count covers up to 2047 bytes; the pad field holds up to 127 bytes.
    localparam int CNT_W = 11;
    localparam int PAD_W = 7;
    localparam int IDX_W = PAD_W;

    localparam int HDR_BYTES = 14;
    localparam int FCS_BYTES = 4;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

    typedef struct packed {
        logic             hdr;
        logic [47:0]      dest_mac;
        logic [15:0]      frame_type;
        logic             data_ok;
        logic [7:0]       data;
        logic             fin;
        logic             err;
        logic [PAD_W-1:0] pad;
    } cmd_t;

    typedef enum logic [2:0] {
        PH_NONE,
        PH_HDR,
        PH_DATA,
        PH_PAD,
        PH_FCS,
        PH_ERR
    } phase_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== design/etxpad_front.sv =====
// ============================================================================
// etxpad_front: input classifier
// Accepts input words, tracks the payload count and the overflow flag, and
// turns each word that produces output into one command for the back end.
// ============================================================================
module etxpad_front #(
    parameter int MIN_PAYLOAD = etxpad_pkg::MIN_PAYLOAD_DEF,
    parameter int MAX_PAYLOAD = etxpad_pkg::MAX_PAYLOAD_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [47:0]        dest_mac,
    input  logic [15:0]        frame_type,
    input  logic [7:0]         data_byte,
    input  logic               byte_valid,
    input  logic               first_item,
    input  logic               last_item,
    input  logic               push,
    output logic               full,
    output logic               q_push,
    output etxpad_pkg::cmd_t   q_cmd,
    input  logic               q_full
);
    import etxpad_pkg::*;

    localparam logic [CNT_W-1:0] MIN_CNT = CNT_W'(MIN_PAYLOAD);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PAYLOAD);

    logic [CNT_W-1:0] count_reg, count_next;
    logic             ovf_reg, ovf_next;
    logic [CNT_W-1:0] cnt0, cnt1;
    logic             ovf0, ovf1, byte_ok, accept;

    assign full   = q_full;
    assign accept = push && !q_full;

    always_comb
    begin
        cnt0    = first_item ? '0 : count_reg;
        ovf0    = first_item ? 1'b0 : ovf_reg;
        byte_ok = byte_valid && !ovf0 && (cnt0 < MAX_CNT);
        ovf1    = ovf0 || (byte_valid && !ovf0 && (cnt0 >= MAX_CNT));
        cnt1    = cnt0 + CNT_W'(byte_ok);

        q_cmd.hdr        = first_item;
        q_cmd.dest_mac   = dest_mac;
        q_cmd.frame_type = frame_type;
        q_cmd.data_ok    = byte_ok;
        q_cmd.data       = data_byte;
        q_cmd.fin        = last_item;
        q_cmd.err        = ovf1;
        q_cmd.pad        = (cnt1 < MIN_CNT) ? PAD_W'(MIN_CNT - cnt1) : '0;

        // A word that produces no output byte is dropped here.
        q_push = accept && (first_item || byte_ok || last_item);

        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (accept)
        begin
            count_next = last_item ? '0 : cnt1;
            ovf_next   = last_item ? 1'b0 : ovf1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

endmodule

// ===== design/etxpad_cmdq.sv =====
// ============================================================================
// etxpad_cmdq: command queue
// Short FIFO between the front end and the back end so that each side can
// stall on its own.
// ============================================================================
module etxpad_cmdq (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  etxpad_pkg::cmd_t wr_cmd,
    output logic             q_full,
    input  logic             rd_en,
    output logic             head_valid,
    output etxpad_pkg::cmd_t head_cmd
);
    import etxpad_pkg::*;

    cmd_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              do_wr, do_rd;

    assign q_full     = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_cmd   = mem[rd_ptr_reg];
    assign do_wr      = wr_en && !q_full;
    assign do_rd      = rd_en && head_valid;

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg + QCNT_W'(do_wr) - QCNT_W'(do_rd);
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// ===== design/etxpad_back.sv =====
// ============================================================================
// etxpad_back: byte sequencer and output stage
// Expands each command into header, payload, pad, FCS or error words, keeps
// the running CRC and holds the oldest result word in an output register.
// ============================================================================
module etxpad_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [47:0]      source_mac,
    input  logic             head_valid,
    input  etxpad_pkg::cmd_t head_cmd,
    output logic             q_pop,
    output logic             empty,
    input  logic             pop,
    output logic [7:0]       out_byte,
    output logic             end_of_frame,
    output logic             too_long
);
    import etxpad_pkg::*;

    phase_t           state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [31:0]      crc_reg, crc_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_byte_reg, out_byte_next;
    logic             eof_reg, eof_next;
    logic             err_reg, err_next;

    phase_t           cur_phase, after_phase;
    logic [IDX_W-1:0] cur_idx;
    logic             emit, phase_done;
    logic [31:0]      fcs;
    logic [7:0]       hdr_bytes [16];
    logic [31:0]      crc_base;

    function automatic phase_t next_phase(input cmd_t c, input phase_t p);
        logic want_hdr, want_data, want_pad, want_fcs, want_err;
        phase_t r;
        want_hdr  = c.hdr && (p == PH_NONE);
        want_data = c.data_ok && (p == PH_NONE || p == PH_HDR);
        want_pad  = c.fin && !c.err && (c.pad != '0)
                    && (p == PH_NONE || p == PH_HDR || p == PH_DATA);
        want_fcs  = c.fin && !c.err && (p != PH_FCS) && (p != PH_ERR);
        want_err  = c.fin && c.err && (p != PH_ERR);
        priority if (want_hdr)  r = PH_HDR;
        else if (want_data)     r = PH_DATA;
        else if (want_pad)      r = PH_PAD;
        else if (want_fcs)      r = PH_FCS;
        else if (want_err)      r = PH_ERR;
        else                    r = PH_NONE;
        return r;
    endfunction

    // Between commands the head command picks its first phase in the same cycle.
    always_comb
    begin
        if (state_reg == PH_NONE)
        begin
            cur_phase = head_valid ? next_phase(head_cmd, PH_NONE) : PH_NONE;
            cur_idx   = '0;
        end
        else
        begin
            cur_phase = state_reg;
            cur_idx   = idx_reg;
        end
        emit = (cur_phase != PH_NONE) && (!out_valid_reg || pop);

        unique case (cur_phase)
            PH_HDR:  phase_done = (cur_idx == IDX_W'(HDR_BYTES - 1));
            PH_PAD:  phase_done = (cur_idx == IDX_W'(head_cmd.pad - PAD_W'(1)));
            PH_FCS:  phase_done = (cur_idx == IDX_W'(FCS_BYTES - 1));
            default: phase_done = 1'b1;
        endcase
        after_phase = next_phase(head_cmd, cur_phase);
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        if (emit)
        begin
            if (phase_done)
            begin
                state_next = after_phase;
                idx_next   = '0;
            end
            else
            begin
                state_next = cur_phase;
                idx_next   = cur_idx + IDX_W'(1);
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 6; i++)
        begin
            hdr_bytes[i]     = head_cmd.dest_mac[8*(5-i) +: 8];
            hdr_bytes[6 + i] = source_mac[8*(5-i) +: 8];
        end
        hdr_bytes[12] = head_cmd.frame_type[15:8];
        hdr_bytes[13] = head_cmd.frame_type[7:0];
        hdr_bytes[14] = 8'd0;
        hdr_bytes[15] = 8'd0;
    end

    // Outputs: result word, CRC update and command retire.
    always_comb
    begin
        fcs      = ~crc_reg;
        crc_base = (cur_phase == PH_HDR && cur_idx == '0) ? CRC_INIT : crc_reg;

        out_byte_next = out_byte_reg;
        eof_next      = eof_reg;
        err_next      = err_reg;
        crc_next      = crc_reg;
        q_pop         = emit && phase_done && (after_phase == PH_NONE);
        out_valid_next = emit || (out_valid_reg && !pop);

        if (emit)
        begin
            eof_next = 1'b0;
            err_next = 1'b0;
            unique case (cur_phase)
                PH_HDR:
                begin
                    out_byte_next = hdr_bytes[cur_idx[3:0]];
                    crc_next      = crc_byte(crc_base, out_byte_next);
                end
                PH_DATA:
                begin
                    out_byte_next = head_cmd.data;
                    crc_next      = crc_byte(crc_base, out_byte_next);
                end
                PH_PAD:
                begin
                    out_byte_next = 8'd0;
                    crc_next      = crc_byte(crc_base, 8'd0);
                end
                PH_FCS:
                begin
                    out_byte_next = fcs[8*cur_idx[1:0] +: 8];
                    eof_next      = phase_done;
                    crc_next      = phase_done ? CRC_INIT : crc_reg;
                end
                PH_ERR:
                begin
                    out_byte_next = 8'd0;
                    eof_next      = 1'b1;
                    err_next      = 1'b1;
                    crc_next      = CRC_INIT;
                end
                default:
                begin
                    out_byte_next = out_byte_reg;
                end
            endcase
        end
    end

    assign empty        = !out_valid_reg;
    assign out_byte     = out_byte_reg;
    assign end_of_frame = eof_reg;
    assign too_long     = err_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= PH_NONE;
            idx_reg       <= '0;
            crc_reg       <= CRC_INIT;
            out_valid_reg <= 1'b0;
            eof_reg       <= 1'b0;
            err_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            crc_reg       <= crc_next;
            out_valid_reg <= out_valid_next;
            eof_reg       <= eof_next;
            err_reg       <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
    end

endmodule

// ===== design/ethernet_tx_pad_and_fcs_unit.sv =====
// ============================================================================
// ethernet_tx_pad_and_fcs_unit: Ethernet transmit framer with pad and FCS
// Adds the header, pads short payloads and appends the CRC-32 frame check.
// ============================================================================
// Throughput: one payload word per cycle unless full or an unpopped result stalls it;
// the back end emits one output word per cycle while its output register is empty
// or being popped, so a first word adds the 14 header bytes and a last word the pad
// bytes plus 4 FCS bytes, and full rises once the 4-entry queue holds four waiting words.
// Reset: asynchronous, active low; clears the queue, the output register, the
// frame count and flag, the CRC to all ones and the source MAC to zero.
module ethernet_tx_pad_and_fcs_unit #(
    parameter int MIN_PAYLOAD = etxpad_pkg::MIN_PAYLOAD_DEF,
    parameter int MAX_PAYLOAD = etxpad_pkg::MAX_PAYLOAD_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        source_mac_wr_en,
    input  logic [47:0] source_mac,
    input  logic [47:0] dest_mac,
    input  logic [15:0] frame_type,
    input  logic [7:0]  data_byte,
    input  logic        byte_valid,
    input  logic        first_item,
    input  logic        last_item,
    input  logic        push,
    output logic        full,
    output logic [7:0]  out_byte,
    output logic        end_of_frame,
    output logic        too_long,
    output logic        empty,
    input  logic        pop
);
    import etxpad_pkg::*;

    logic [47:0] source_mac_reg;
    logic        q_push, q_full, q_pop, head_valid;
    cmd_t        q_cmd, head_cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_mac_reg <= '0;
        end
        else if (source_mac_wr_en)
        begin
            source_mac_reg <= source_mac;
        end
    end

    etxpad_front #(
        .MIN_PAYLOAD (MIN_PAYLOAD),
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .dest_mac   (dest_mac),
        .frame_type (frame_type),
        .data_byte  (data_byte),
        .byte_valid (byte_valid),
        .first_item (first_item),
        .last_item  (last_item),
        .push       (push),
        .full       (full),
        .q_push     (q_push),
        .q_cmd      (q_cmd),
        .q_full     (q_full)
    );

    etxpad_cmdq u_cmdq (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (q_push),
        .wr_cmd     (q_cmd),
        .q_full     (q_full),
        .rd_en      (q_pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    etxpad_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .source_mac   (source_mac_reg),
        .head_valid   (head_valid),
        .head_cmd     (head_cmd),
        .q_pop        (q_pop),
        .empty        (empty),
        .pop          (pop),
        .out_byte     (out_byte),
        .end_of_frame (end_of_frame),
        .too_long     (too_long)
    );

endmodule

// ===== design/etxpad_checker.sv =====
// ============================================================================
// etxpad_checker: port-level checks for the Ethernet transmit framer
// Watches the result side of the top level and is bound to it below.
// ============================================================================
module etxpad_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       empty,
    input logic       pop,
    input logic [7:0] out_byte,
    input logic       end_of_frame,
    input logic       too_long
);

    // A cycle under reset leaves the output register empty.
    a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
        else $error("result shown during reset");

    // An error word always closes the frame and carries a zero byte.
    a_err_word: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && too_long) |-> (end_of_frame && out_byte == 8'd0))
        else $error("malformed error word");

    // A waiting result stays until it is taken.
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> !empty)
        else $error("result withdrawn before pop");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> ($stable(out_byte) && $stable(end_of_frame)
                              && $stable(too_long)))
        else $error("result changed before pop");

endmodule

bind ethernet_tx_pad_and_fcs_unit etxpad_checker u_etxpad_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .empty        (empty),
    .pop          (pop),
    .out_byte     (out_byte),
    .end_of_frame (end_of_frame),
    .too_long     (too_long)
);

// ===== sim/etxpad_frame_monitor.sv =====
// ============================================================================
// etxpad_frame_monitor: result predictor and comparator for the framer
// Watches the input and output queues of the Ethernet transmit framer. It
// works out the header, payload, pad and FCS words that each accepted input
// word causes, and checks every popped word against the oldest one waiting.
// ============================================================================
module etxpad_frame_monitor
    import etxpad_pkg::*;
#(
    parameter int MIN_PAYLOAD = MIN_PAYLOAD_DEF,
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        source_mac_wr_en,
    input  logic [47:0] source_mac,
    input  logic [47:0] dest_mac,
    input  logic [15:0] frame_type,
    input  logic [7:0]  data_byte,
    input  logic        byte_valid,
    input  logic        first_item,
    input  logic        last_item,
    input  logic        push,
    input  logic        full,
    input  logic [7:0]  out_byte,
    input  logic        end_of_frame,
    input  logic        too_long,
    input  logic        empty,
    input  logic        pop,
    output int          mismatches,
    output int          words_waiting
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] data;
        logic       eof;
        logic       err;
    } wire_word_t;

    wire_word_t  frame_words[$];
    logic [31:0] crc_acc;
    int          payload_len;
    logic        overrun;
    logic [47:0] src_addr;

    // Bit-serial form of the reflected CRC-32, least significant bit first.
    function automatic logic [31:0] crc_fold(input logic [31:0] acc, input logic [7:0] b);
        logic [31:0] r;
        logic        fb;
        r = acc;
        for (int i = 0; i < 8; i++)
        begin
            fb = r[0] ^ b[i];
            r = {1'b0, r[31:1]} ^ (fb ? CRC_POLY : 32'd0);
        end
        return r;
    endfunction

    task automatic restart_frame();
        crc_acc = CRC_INIT;
        payload_len = 0;
        overrun = 1'b0;
    endtask

    task automatic queue_word(input logic [7:0] d, input logic eof, input logic err);
        wire_word_t w;
        w.data = d;
        w.eof = eof;
        w.err = err;
        frame_words.push_back(w);
    endtask

    task automatic queue_framed(input logic [7:0] d);
        crc_acc = crc_fold(crc_acc, d);
        queue_word(d, 1'b0, 1'b0);
    endtask

    task automatic predict_frame_words();
        logic [31:0] fcs;
        if (first_item)
        begin
            restart_frame();
            for (int i = 5; i >= 0; i--)
                queue_framed(dest_mac[8*i +: 8]);
            for (int i = 5; i >= 0; i--)
                queue_framed(src_addr[8*i +: 8]);
            queue_framed(frame_type[15:8]);
            queue_framed(frame_type[7:0]);
        end
        // Once the payload has run past the maximum, every further byte is dropped.
        if (byte_valid && !overrun)
        begin
            if (payload_len < MAX_PAYLOAD)
            begin
                queue_framed(data_byte);
                payload_len++;
            end
            else
            begin
                overrun = 1'b1;
            end
        end
        if (last_item)
        begin
            if (overrun)
            begin
                queue_word(8'h00, 1'b1, 1'b1);
            end
            else
            begin
                while (payload_len < MIN_PAYLOAD)
                begin
                    queue_framed(8'h00);
                    payload_len++;
                end
                fcs = ~crc_acc;
                queue_word(fcs[7:0], 1'b0, 1'b0);
                queue_word(fcs[15:8], 1'b0, 1'b0);
                queue_word(fcs[23:16], 1'b0, 1'b0);
                queue_word(fcs[31:24], 1'b1, 1'b0);
            end
            restart_frame();
        end
    endtask

    task automatic check_frame_word();
        wire_word_t want;
        if (frame_words.size() == 0)
        begin
            if (mismatches < 10)
                $display("unexpected word: out_byte=%02h end_of_frame=%b too_long=%b",
                         out_byte, end_of_frame, too_long);
            mismatches++;
        end
        else
        begin
            want = frame_words.pop_front();
            if (out_byte !== want.data || end_of_frame !== want.eof || too_long !== want.err)
            begin
                if (mismatches < 10)
                    $display("mismatch: expected out_byte=%02h end_of_frame=%b too_long=%b, got out_byte=%02h end_of_frame=%b too_long=%b",
                             want.data, want.eof, want.err, out_byte, end_of_frame, too_long);
                mismatches++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_words.delete();
            restart_frame();
            src_addr = '0;
            mismatches = 0;
            words_waiting = 0;
        end
        else
        begin
            if (source_mac_wr_en)
                src_addr = source_mac;
            if (push && !full)
                predict_frame_words();
            if (pop && !empty)
                check_frame_word();
            words_waiting = frame_words.size();
        end
    end

endmodule

// ===== sim/ethernet_tx_pad_and_fcs_unit_tb.sv =====
// ============================================================================
// ethernet_tx_pad_and_fcs_unit_tb: stimulus and verdict for the framer
// Drives directed frames (empty, headerless, abandoned, maximum length and
// overlong payloads) and then random frames with noise words, under random
// idling on both queues, a long output hold-off and several source MACs.
// ============================================================================
module ethernet_tx_pad_and_fcs_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_PCT     = 30;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_WORDS = 130;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int MAX_LEN      = etxpad_pkg::MAX_PAYLOAD_DEF;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        source_mac_wr_en = 1'b0;
    logic [47:0] source_mac = '0;
    logic [47:0] dest_mac = '0;
    logic [15:0] frame_type = '0;
    logic [7:0]  data_byte = '0;
    logic        byte_valid = 1'b0;
    logic        first_item = 1'b0;
    logic        last_item = 1'b0;
    logic        push = 1'b0;
    logic        pop = 1'b0;
    logic        full;
    logic        empty;
    logic [7:0]  out_byte;
    logic        end_of_frame;
    logic        too_long;

    int mismatches;
    int words_waiting;
    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;
    int hold_requests = 0;
    int holds_served = 0;
    int words_sent = 0;
    int cycle_count = 0;

    ethernet_tx_pad_and_fcs_unit uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .source_mac_wr_en (source_mac_wr_en),
        .source_mac       (source_mac),
        .dest_mac         (dest_mac),
        .frame_type       (frame_type),
        .data_byte        (data_byte),
        .byte_valid       (byte_valid),
        .first_item       (first_item),
        .last_item        (last_item),
        .push             (push),
        .full             (full),
        .out_byte         (out_byte),
        .end_of_frame     (end_of_frame),
        .too_long         (too_long),
        .empty            (empty),
        .pop              (pop)
    );

    etxpad_frame_monitor frame_mon (
        .clk              (clk),
        .rst_n            (rst_n),
        .source_mac_wr_en (source_mac_wr_en),
        .source_mac       (source_mac),
        .dest_mac         (dest_mac),
        .frame_type       (frame_type),
        .data_byte        (data_byte),
        .byte_valid       (byte_valid),
        .first_item       (first_item),
        .last_item        (last_item),
        .push             (push),
        .full             (full),
        .out_byte         (out_byte),
        .end_of_frame     (end_of_frame),
        .too_long         (too_long),
        .empty            (empty),
        .pop              (pop),
        .mismatches       (mismatches),
        .words_waiting    (words_waiting)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic [47:0] rand_mac();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[47:0];
    endfunction

    task automatic send_word(input logic [47:0] d, input logic [15:0] t, input logic [7:0] b,
                             input logic v, input logic f, input logic l);
        int gap;
        if (tx_idle_on && $urandom_range(0, 99) < IDLE_PCT)
        begin
            gap = $urandom_range(1, 4);
            repeat (gap)
            begin
                @(negedge clk);
                push = 1'b0;
            end
        end
        @(negedge clk);
        dest_mac = d;
        frame_type = t;
        data_byte = b;
        byte_valid = v;
        first_item = f;
        last_item = l;
        push = 1'b1;
        @(posedge clk);
        while (full)
            @(posedge clk);
        if (v || f || l)
            words_sent++;
    endtask

    // With empty_tail the frame closes on an extra word that carries no byte.
    task automatic send_frame(input int n_bytes, input bit empty_tail, input bit noisy);
        logic [47:0] d;
        logic [15:0] t;
        d = rand_mac();
        t = 16'($urandom_range(0, 65535));
        for (int k = 0; k < n_bytes; k++)
        begin
            if (noisy && $urandom_range(0, 99) < 8)
                send_word(rand_mac(), 16'($urandom_range(0, 65535)),
                          8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)), $urandom_range(0, 9) == 0,
                          $urandom_range(0, 9) == 0);
            send_word(d, t, 8'($urandom_range(0, 255)), 1'b1, k == 0,
                      !empty_tail && k == n_bytes - 1);
        end
        if (n_bytes == 0 || empty_tail)
            send_word(d, t, 8'($urandom_range(0, 255)), 1'b0, n_bytes == 0, 1'b1);
    endtask

    task automatic send_random_frame();
        int pick;
        int n;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            n = $urandom_range(0, 8);
        else if (pick < 75)
            n = $urandom_range(44, 48);
        else
            n = $urandom_range(9, 30);
        send_frame(n, $urandom_range(0, 3) == 0, 1'b1);
    endtask

    // Waits until every predicted word has been popped, then lets any
    // word that causes no output leave the pipeline.
    task automatic drain_block();
        @(negedge clk);
        push = 1'b0;
        wait (words_waiting == 0);
        repeat (DRAIN_CYCLES)
            @(negedge clk);
    endtask

    task automatic write_source_mac(input logic [47:0] v);
        @(negedge clk);
        source_mac_wr_en = 1'b1;
        source_mac = v;
        @(negedge clk);
        source_mac_wr_en = 1'b0;
    endtask

    // Output side: random pops, with a long hold-off whenever one is requested.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_requests != holds_served)
            begin
                pop = 1'b0;
                repeat (HOLD_CYCLES - 1)
                    @(negedge clk);
                holds_served++;
            end
            else
            begin
                pop = !rx_idle_on || $urandom_range(0, 99) >= IDLE_PCT;
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    initial
    begin
        int base;
        repeat (8)
            @(negedge clk);
        rst_n = 1'b1;

        // Source MAC still at its reset value; empty payload, all-ones header fields.
        send_word(48'hFFFF_FFFF_FFFF, 16'hFFFF, 8'h00, 1'b0, 1'b1, 1'b1);
        drain_block();
        write_source_mac(48'hFFFF_FFFF_FFFF);
        send_word(48'h0, 16'h0, 8'hFF, 1'b1, 1'b1, 1'b1);
        send_word(rand_mac(), 16'h0800, 8'h00, 1'b1, 1'b1, 1'b0);
        send_word(rand_mac(), 16'h0, 8'h80, 1'b1, 1'b0, 1'b0);
        send_word(rand_mac(), 16'h0, 8'h01, 1'b1, 1'b0, 1'b0);
        send_word(rand_mac(), 16'h0, 8'h7F, 1'b1, 1'b0, 1'b0);
        send_word(rand_mac(), 16'h0, 8'h00, 1'b0, 1'b0, 1'b1);
        // Payload with no header, then a frame end on its own.
        send_word(rand_mac(), 16'h0, 8'hA5, 1'b1, 1'b0, 1'b0);
        send_word(rand_mac(), 16'h0, 8'h5A, 1'b1, 1'b0, 1'b1);
        send_word(rand_mac(), 16'h0, 8'h00, 1'b0, 1'b0, 1'b1);
        // A new frame starts while one is still open.
        send_word(rand_mac(), 16'h86DD, 8'h11, 1'b1, 1'b1, 1'b0);
        send_word(rand_mac(), 16'h0, 8'h22, 1'b1, 1'b0, 1'b0);
        send_word(rand_mac(), 16'h88CC, 8'h33, 1'b1, 1'b1, 1'b0);
        send_word(rand_mac(), 16'h0, 8'h44, 1'b1, 1'b0, 1'b1);
        send_word(rand_mac(), 16'h1234, 8'hC3, 1'b0, 1'b0, 1'b0);
        drain_block();
        write_source_mac(rand_mac());

        // Maximum payload with no idling at all, then overlong payloads.
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        send_frame(MAX_LEN, 1'b0, 1'b0);
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        send_frame(MAX_LEN + 2, 1'b0, 1'b0);
        send_frame(MAX_LEN + 1, 1'b1, 1'b0);
        drain_block();
        write_source_mac(48'h0);

        base = words_sent;
        while (words_sent - base < RANDOM_WORDS / 2)
            send_random_frame();
        // Hold the output back while input keeps coming, so the block backs up.
        hold_requests++;
        send_frame(40, 1'b0, 1'b0);
        drain_block();
        write_source_mac(rand_mac());
        base = words_sent;
        while (words_sent - base < RANDOM_WORDS / 2)
            send_random_frame();
        drain_block();

        if (mismatches == 0 && words_waiting == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
